[rtl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Types and constants for the packet steering classifier.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 64;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	// configuration register indexes
	localparam cfg_index_t REG_SOCKET_MAP    = 1'b0;
	localparam cfg_index_t REG_EXCLUDED_PORT = 1'b1;

	localparam logic [15:0] DEFAULT_EXCLUDED_PORT = 16'd22;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

	// header sizes in bytes, and the minimum IHL in 32-bit words
	localparam logic [6:0] ETH_LEN      = 7'd14;
	localparam logic [6:0] IPV4_MIN_LEN = 7'd20;
	localparam logic [6:0] TCP_LEN      = 7'd20;
	localparam logic [6:0] UDP_LEN      = 7'd8;
	localparam logic [3:0] MIN_IHL      = 4'd5;

	// byte offsets from the start of the frame
	localparam logic [15:0] POS_ETYPE_HI = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO = 16'd13;
	localparam logic [15:0] POS_IHL      = 16'd14;
	localparam logic [15:0] POS_PROTO    = 16'd23;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	// byte within the four layer-4 port bytes
	typedef enum logic [1:0] {
		L4_SRC_HI = 2'd0,
		L4_SRC_LO = 2'd1,
		L4_DST_HI = 2'd2,
		L4_DST_LO = 2'd3
	} l4_byte_t;

endpackage

[rtl/packet_steer_classifier.sv]
// ----------------------------------------------------------------------------
// packet_steer_classifier
// Byte-serial Ethernet/IPv4 frame classifier giving a steering verdict.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) carries one frame byte per request,
//    with last_byte marking the final byte and rx_queue the frame's queue.
//  - Output channel (out_valid/out_stall) carries one verdict per frame,
//    issued for the last byte only; target_queue is that byte's rx_queue.
//  - Config port: cfg_we writes cfg_data to register cfg_index
//    (0 socket_map, 1 excluded_port). Write only while the block is idle.
//  - Throughput: one byte per cycle while in_stall is low. Each byte sits in the input
//    register, where the header captures and the verdict are worked out.
//  - Result register: the verdict and target_queue are loaded when the last
//    byte leaves the input register, and out_valid rises with them.
//  - Stall: non-last bytes keep flowing while a verdict waits. A last byte
//    waits in the input register, and in_stall is raised, only while the
//    previous verdict is still held by out_stall.
//  - Reset: clears frame state, empties both registers, socket_map to 0
//    and excluded_port to 22.
// ----------------------------------------------------------------------------
module packet_steer_classifier #(
	parameter int QUEUES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  psc_pkg::cfg_index_t           cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data,
	// byte input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    pkt_byte,
	input  logic                          last_byte,
	input  logic [7:0]                    rx_queue,
	// verdict output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          verdict,
	output logic [7:0]                    target_queue
);

	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	// configuration registers
	logic [QUEUES-1:0] socket_map_q;
	logic [15:0]       excluded_port_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [7:0] queue_s1;

	// frame state
	logic [15:0] byte_count_q;
	logic [15:0] ether_type_q;
	logic [3:0]  header_words_q;
	logic [7:0]  proto_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;

	// result register
	logic       out_valid_q;
	logic       verdict_q;
	logic [7:0] target_q;

	logic accept;
	logic advance;
	logic out_free;

	logic [15:0] ether_type_d;
	logic [3:0]  header_words_d;
	logic [7:0]  proto_d;
	logic [15:0] src_port_d;
	logic [15:0] dst_port_d;
	logic [6:0]  l4_cur;
	logic [16:0] l4_diff;
	logic        in_l4;
	logic [16:0] frame_len;
	logic [6:0]  l4_new;
	logic        queue_bound;
	logic        verdict_d;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign target_queue = target_q;

	// header capture for the byte in the input register
	assign l4_cur  = psc_pkg::ETH_LEN + {1'b0, header_words_q, 2'b00};
	assign l4_diff = {1'b0, byte_count_q} - {10'd0, l4_cur};
	assign in_l4   = !l4_diff[16] && (l4_diff[15:2] == 14'd0);

	always_comb begin
		ether_type_d   = ether_type_q;
		header_words_d = header_words_q;
		proto_d        = proto_q;
		src_port_d     = src_port_q;
		dst_port_d     = dst_port_q;
		if (byte_count_q == psc_pkg::POS_ETYPE_HI) begin
			ether_type_d[15:8] = byte_s1;
		end else if (byte_count_q == psc_pkg::POS_ETYPE_LO) begin
			ether_type_d[7:0] = byte_s1;
		end else if (byte_count_q == psc_pkg::POS_IHL) begin
			header_words_d = byte_s1[3:0];
		end else if (byte_count_q == psc_pkg::POS_PROTO) begin
			proto_d = byte_s1;
		end
		if (in_l4) begin
			unique case (psc_pkg::l4_byte_t'(l4_diff[1:0]))
				psc_pkg::L4_SRC_HI: src_port_d[15:8] = byte_s1;
				psc_pkg::L4_SRC_LO: src_port_d[7:0]  = byte_s1;
				psc_pkg::L4_DST_HI: dst_port_d[15:8] = byte_s1;
				psc_pkg::L4_DST_LO: dst_port_d[7:0]  = byte_s1;
				default:            src_port_d       = src_port_q;
			endcase
		end
	end

	// verdict, from the state including this byte
	assign frame_len   = {1'b0, byte_count_q} + 17'd1;
	assign l4_new      = psc_pkg::ETH_LEN + {1'b0, header_words_d, 2'b00};
	assign queue_bound = (queue_s1 < 8'(QUEUES)) && socket_map_q[queue_s1[QW-1:0]];

	always_comb begin
		priority if (frame_len < 17'(psc_pkg::ETH_LEN)) begin
			verdict_d = 1'b0;
		end else if (ether_type_d != psc_pkg::ETHERTYPE_IPV4) begin
			verdict_d = 1'b0;
		end else if (frame_len < 17'(psc_pkg::ETH_LEN + psc_pkg::IPV4_MIN_LEN)) begin
			verdict_d = 1'b0;
		end else if (header_words_d < psc_pkg::MIN_IHL) begin
			verdict_d = 1'b0;
		end else if (frame_len < 17'(l4_new)) begin
			verdict_d = 1'b0;
		end else if (proto_d == psc_pkg::PROTO_TCP) begin
			if (frame_len < 17'(l4_new) + 17'(psc_pkg::TCP_LEN)) begin
				verdict_d = 1'b0;
			end else if (src_port_d == excluded_port_q || dst_port_d == excluded_port_q) begin
				verdict_d = 1'b0;
			end else begin
				verdict_d = queue_bound;
			end
		end else if (proto_d == psc_pkg::PROTO_UDP) begin
			verdict_d = (frame_len >= 17'(l4_new) + 17'(psc_pkg::UDP_LEN)) && queue_bound;
		end else if (proto_d == psc_pkg::PROTO_ICMP) begin
			verdict_d = 1'b0;
		end else begin
			verdict_d = queue_bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			socket_map_q    <= '0;
			excluded_port_q <= psc_pkg::DEFAULT_EXCLUDED_PORT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psc_pkg::REG_SOCKET_MAP:    socket_map_q    <= cfg_data[QUEUES-1:0];
				psc_pkg::REG_EXCLUDED_PORT: excluded_port_q <= cfg_data[15:0];
				default:                    socket_map_q    <= socket_map_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= pkt_byte;
			last_s1  <= last_byte;
			queue_s1 <= rx_queue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			ether_type_q   <= '0;
			header_words_q <= '0;
			proto_q        <= '0;
			src_port_q     <= '0;
			dst_port_q     <= '0;
		end else if (advance) begin
			if (last_s1) begin
				byte_count_q   <= '0;
				ether_type_q   <= '0;
				header_words_q <= '0;
				proto_q        <= '0;
				src_port_q     <= '0;
				dst_port_q     <= '0;
			end else begin
				// count saturates on very long frames
				if (byte_count_q != 16'hFFFF) begin
					byte_count_q <= byte_count_q + 16'd1;
				end
				ether_type_q   <= ether_type_d;
				header_words_q <= header_words_d;
				proto_q        <= proto_d;
				src_port_q     <= src_port_d;
				dst_port_q     <= dst_port_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict_d;
			target_q  <= queue_s1;
		end
	end

`ifndef SYNTHESIS
	a_redirect_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q |-> target_q < 8'(QUEUES))
		else $error("redirect to a queue with no socket map bit");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked verdict");

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> byte_count_q == 16'd0 && header_words_q == 4'd0)
		else $error("frame state not cleared after last byte");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && byte_count_q != 16'hFFFF
		|=> byte_count_q == $past(byte_count_q) + 16'd1)
		else $error("byte count did not advance");

	a_verdict_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid_q && target_q == $past(queue_s1))
		else $error("verdict not loaded for last byte");
`endif

endmodule
